// File: hdl/ctc_pkg.sv
package ctc_pkg;

   localparam int L1_LINE_COUNT_DEF = 256;
   localparam int L2_LINE_COUNT_DEF = 512;
   localparam int BLOCK_BYTES_DEF   = 64;
   localparam int MEMORY_BYTES_DEF  = 1048576;

   localparam int ADDR_W  = 20;
   localparam int WORD_W  = 32;
   localparam int COST_W  = 10;
   localparam int CFG_W   = 8;
   localparam int CIDX_W  = 3;
   localparam int ACC_W   = 11;
   localparam int TIME_W  = 32;

   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic [CIDX_W-1:0] {
      CFG_L1_READ  = 3'd0,
      CFG_L1_WRITE = 3'd1,
      CFG_L2_READ  = 3'd2,
      CFG_L2_WRITE = 3'd3,
      CFG_MEM_READ = 3'd4,
      CFG_MEM_WRITE = 3'd5
   } cfg_index_type;

   typedef struct packed {
      logic [CFG_W-1:0] l1_read;
      logic [CFG_W-1:0] l1_write;
      logic [CFG_W-1:0] l2_read;
      logic [CFG_W-1:0] l2_write;
      logic [CFG_W-1:0] mem_read;
      logic [CFG_W-1:0] mem_write;
   } cost_cfg_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_L1_CHK,
      S_L2W_LOOK, S_L2W_CHK, S_L2W_FILL,
      S_L2R_LOOK, S_L2R_CHK, S_L2R_FILL, S_L2R_XFER,
      S_COPY, S_WORD, S_WORD_RD, S_DONE
   } state_type;

   typedef enum logic [1:0] {
      CP_L1_L2, CP_L2_MEM, CP_MEM_L2, CP_L2_L1
   } copy_kind_type;

endpackage

// File: hdl/ctc_req_if.sv
interface ctc_req_if import ctc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] address;
   logic [WORD_W-1:0] write_data;

   modport source (output valid, command, address, write_data, input ready);
   modport sink (input valid, command, address, write_data, output ready);
endinterface

// File: hdl/ctc_rsp_if.sv
interface ctc_rsp_if import ctc_pkg::*; ;
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              l1_hit;
   logic              l2_hit;
   logic [COST_W-1:0] access_cost;
   logic [TIME_W-1:0] elapsed_time;

   modport source (output valid, read_data, l1_hit, l2_hit, access_cost, elapsed_time,
                   input ready);
   modport sink (input valid, read_data, l1_hit, l2_hit, access_cost, elapsed_time,
                 output ready);
endinterface

// File: hdl/two_level_writeback_cache.sv
// two-level direct-mapped write-back, write-allocate cache in front of a word memory.
// one item (word read or write) is taken at a time. after reset a clearing pass zeroes
// the backing memory and both tag stores; req_ready stays low meanwhile (csr writes are
// still taken). an l1 hit goes through S_L1_CHK and S_DONE before its result is loaded
// into the output register. a miss adds l2 tag lookups and block copies over the
// one-word-wide data memories: up to four copies (l1 victim to l2, l2 victim to memory,
// memory to l2, l2 to l1) plus a second l2 victim copy in the worst case.
// a finished result sits in the output register while the next item may wait on req_ready.
module two_level_writeback_cache import ctc_pkg::*; #(
   parameter int L1_LINE_COUNT = L1_LINE_COUNT_DEF,
   parameter int L2_LINE_COUNT = L2_LINE_COUNT_DEF,
   parameter int BLOCK_BYTES   = BLOCK_BYTES_DEF,
   parameter int MEMORY_BYTES  = MEMORY_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   ctc_req_if.sink           req_ch,
   ctc_rsp_if.source         rsp_ch,
   input  logic              csr_write,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_data
);

   localparam int WPB = BLOCK_BYTES / 4;
   localparam int WO  = $clog2(WPB);
   localparam int OB  = $clog2(BLOCK_BYTES);
   localparam int MA  = $clog2(MEMORY_BYTES);
   localparam int BW  = MA - OB;
   localparam int I1  = $clog2(L1_LINE_COUNT);
   localparam int I2  = $clog2(L2_LINE_COUNT);
   localparam int T1  = BW - I1;
   localparam int T2  = BW - I2;
   localparam int MWA = MA - 2;

   cost_cfg_type costs;

   ctc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .costs     (costs)
   );

   // memory ports
   logic              l1d_we;
   logic [I1+WO-1:0]  l1d_waddr, l1d_raddr;
   logic [WORD_W-1:0] l1d_wdata, l1d_rdata;
   logic              l1m_we;
   logic [I1-1:0]     l1m_waddr, l1m_raddr;
   logic [T1+1:0]     l1m_wdata, l1m_rdata;
   logic              l2d_we;
   logic [I2+WO-1:0]  l2d_waddr, l2d_raddr;
   logic [WORD_W-1:0] l2d_wdata, l2d_rdata;
   logic              l2m_we;
   logic [I2-1:0]     l2m_waddr, l2m_raddr;
   logic [T2+1:0]     l2m_wdata, l2m_rdata;
   logic              mem_we;
   logic [MWA-1:0]    mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   ctc_ram #(.WIDTH(WORD_W), .DEPTH(L1_LINE_COUNT * WPB)) u_l1_data (
      .clock(clock), .we(l1d_we), .waddr(l1d_waddr), .wdata(l1d_wdata),
      .raddr(l1d_raddr), .rdata(l1d_rdata));
   ctc_ram #(.WIDTH(T1 + 2), .DEPTH(L1_LINE_COUNT)) u_l1_meta (
      .clock(clock), .we(l1m_we), .waddr(l1m_waddr), .wdata(l1m_wdata),
      .raddr(l1m_raddr), .rdata(l1m_rdata));
   ctc_ram #(.WIDTH(WORD_W), .DEPTH(L2_LINE_COUNT * WPB)) u_l2_data (
      .clock(clock), .we(l2d_we), .waddr(l2d_waddr), .wdata(l2d_wdata),
      .raddr(l2d_raddr), .rdata(l2d_rdata));
   ctc_ram #(.WIDTH(T2 + 2), .DEPTH(L2_LINE_COUNT)) u_l2_meta (
      .clock(clock), .we(l2m_we), .waddr(l2m_waddr), .wdata(l2m_wdata),
      .raddr(l2m_raddr), .rdata(l2m_rdata));
   ctc_ram #(.WIDTH(WORD_W), .DEPTH(MEMORY_BYTES / 4)) u_backing (
      .clock(clock), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
      .raddr(mem_raddr), .rdata(mem_rdata));

   // control and item registers
   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;
   copy_kind_type     kind_ff, kind_in;
   logic [WO:0]       cnt_ff, cnt_in;
   logic [MWA-1:0]    clr_ff, clr_in;
   logic              cmd_ff, cmd_in;
   logic [MA-1:0]     addr_ff, addr_in;
   logic [WORD_W-1:0] wdata_ff, wdata_in;
   logic [ACC_W-1:0]  cost_ff, cost_in;
   logic              hit1_ff, hit1_in;
   logic              hit2_ff, hit2_in;
   logic [WORD_W-1:0] rdata_ff, rdata_in;
   logic [BW-1:0]     op2_ff, op2_in;
   logic [I2-1:0]     l2_line_ff, l2_line_in;
   logic [BW-1:0]     mem_line_ff, mem_line_in;
   logic [TIME_W-1:0] time_ff, time_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic              rsp_hit1_ff, rsp_hit1_in;
   logic              rsp_hit2_ff, rsp_hit2_in;
   logic [COST_W-1:0] rsp_cost_ff, rsp_cost_in;

   // address split
   logic [MA-1:0] req_addr;
   logic [BW-1:0] req_blk, blk;
   logic [WO-1:0] req_word, word;
   logic [I1-1:0] idx1;
   logic [T1-1:0] tag1;
   logic [T2-1:0] op2_tag;
   logic [WO-1:0] rw, ww;
   logic          l1_hit_now, l2_hit_now;
   logic          load;

   assign req_addr = MA'(req_ch.address);
   assign req_blk  = req_addr[MA-1:OB];
   assign req_word = req_addr[OB-1:2];
   assign blk      = addr_ff[MA-1:OB];
   assign word     = addr_ff[OB-1:2];
   assign idx1     = blk[I1-1:0];
   assign tag1     = blk[BW-1:I1];
   assign op2_tag  = op2_ff[BW-1:I2];
   assign rw       = cnt_ff[WO-1:0];
   assign ww       = WO'(cnt_ff - 1'b1);

   // meta layout is {valid, dirty, tag}
   assign l1_hit_now = l1m_rdata[T1+1] && (l1m_rdata[T1-1:0] == tag1);
   assign l2_hit_now = l2m_rdata[T2+1] && (l2m_rdata[T2-1:0] == op2_tag);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      kind_in     = kind_ff;
      cnt_in      = cnt_ff;
      clr_in      = clr_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      wdata_in    = wdata_ff;
      cost_in     = cost_ff;
      hit1_in     = hit1_ff;
      hit2_in     = hit2_ff;
      rdata_in    = rdata_ff;
      op2_in      = op2_ff;
      l2_line_in  = l2_line_ff;
      mem_line_in = mem_line_ff;
      time_in     = time_ff;

      l1d_we = 1'b0; l1d_waddr = {idx1, word}; l1d_wdata = wdata_ff;
      l1d_raddr = {idx1, word};
      l1m_we = 1'b0; l1m_waddr = idx1; l1m_wdata = {1'b1, 1'b0, tag1};
      l1m_raddr = idx1;
      l2d_we = 1'b0; l2d_waddr = {l2_line_ff, ww}; l2d_wdata = l1d_rdata;
      l2d_raddr = {l2_line_ff, rw};
      l2m_we = 1'b0; l2m_waddr = l2_line_ff; l2m_wdata = {1'b1, 1'b0, op2_tag};
      l2m_raddr = op2_ff[I2-1:0];
      mem_we = 1'b0; mem_waddr = {mem_line_ff, ww}; mem_wdata = l2d_rdata;
      mem_raddr = {mem_line_ff, rw};

      case (state_ff)
         S_CLEAR: begin
            // zero backing memory and both tag stores, one word a cycle
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            l1m_we    = 1'b1;
            l1m_waddr = clr_ff[I1-1:0];
            l1m_wdata = '0;
            l2m_we    = 1'b1;
            l2m_waddr = clr_ff[I2-1:0];
            l2m_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            // look up tag and the word itself right away
            l1m_raddr = req_blk[I1-1:0];
            l1d_raddr = {req_blk[I1-1:0], req_word};
            if (req_ch.valid) begin
               cmd_in   = req_ch.command;
               addr_in  = req_addr;
               wdata_in = req_ch.write_data;
               cost_in  = '0;
               hit2_in  = 1'b0;
               rdata_in = '0;
               state_in = S_L1_CHK;
            end
         end
         S_L1_CHK: begin
            hit1_in = l1_hit_now;
            if (l1_hit_now) begin
               if (!cmd_ff) begin
                  rdata_in = l1d_rdata;
                  cost_in  = cost_ff + ACC_W'(costs.l1_read);
               end else begin
                  l1d_we    = 1'b1;
                  l1m_we    = 1'b1;
                  l1m_wdata = {1'b1, 1'b1, tag1};
                  cost_in   = cost_ff + ACC_W'(costs.l1_write);
               end
               state_in = S_DONE;
            end else if (l1m_rdata[T1+1] && l1m_rdata[T1]) begin
               // dirty victim goes back to its own block in l2
               op2_in   = {l1m_rdata[T1-1:0], idx1};
               state_in = S_L2W_LOOK;
            end else begin
               op2_in   = blk;
               state_in = S_L2R_LOOK;
            end
         end
         S_L2W_LOOK: begin
            l2_line_in = op2_ff[I2-1:0];
            state_in   = S_L2W_CHK;
         end
         S_L2W_CHK: begin
            state_in = S_L2W_FILL;
            if (!l2_hit_now && l2m_rdata[T2+1] && l2m_rdata[T2]) begin
               mem_line_in = {l2m_rdata[T2-1:0], l2_line_ff};
               cost_in     = cost_ff + ACC_W'(costs.mem_write);
               kind_in     = CP_L2_MEM;
               ret_in      = S_L2W_FILL;
               cnt_in      = '0;
               state_in    = S_COPY;
            end
         end
         S_L2W_FILL: begin
            // whole block overwritten: no memory read
            l2m_we    = 1'b1;
            l2m_wdata = {1'b1, 1'b1, op2_tag};
            cost_in   = cost_ff + ACC_W'(costs.l2_write);
            op2_in    = blk;
            kind_in   = CP_L1_L2;
            ret_in    = S_L2R_LOOK;
            cnt_in    = '0;
            state_in  = S_COPY;
         end
         S_L2R_LOOK: begin
            l2_line_in = op2_ff[I2-1:0];
            state_in   = S_L2R_CHK;
         end
         S_L2R_CHK: begin
            hit2_in = l2_hit_now;
            if (l2_hit_now) begin
               state_in = S_L2R_XFER;
            end else if (l2m_rdata[T2+1] && l2m_rdata[T2]) begin
               mem_line_in = {l2m_rdata[T2-1:0], l2_line_ff};
               cost_in     = cost_ff + ACC_W'(costs.mem_write);
               kind_in     = CP_L2_MEM;
               ret_in      = S_L2R_FILL;
               cnt_in      = '0;
               state_in    = S_COPY;
            end else begin
               state_in = S_L2R_FILL;
            end
         end
         S_L2R_FILL: begin
            l2m_we      = 1'b1;
            l2m_wdata   = {1'b1, 1'b0, op2_tag};
            cost_in     = cost_ff + ACC_W'(costs.mem_read);
            mem_line_in = blk;
            kind_in     = CP_MEM_L2;
            ret_in      = S_L2R_XFER;
            cnt_in      = '0;
            state_in    = S_COPY;
         end
         S_L2R_XFER: begin
            l1m_we   = 1'b1;
            cost_in  = cost_ff + ACC_W'(costs.l2_read);
            kind_in  = CP_L2_L1;
            ret_in   = S_WORD;
            cnt_in   = '0;
            state_in = S_COPY;
         end
         S_COPY: begin
            // read word cnt, write word cnt-1 with last cycle's read data
            case (kind_ff)
               CP_L1_L2: begin
                  l1d_raddr = {idx1, rw};
                  l2d_we    = (cnt_ff != '0);
                  l2d_wdata = l1d_rdata;
               end
               CP_L2_MEM: begin
                  mem_we    = (cnt_ff != '0);
                  mem_wdata = l2d_rdata;
               end
               CP_MEM_L2: begin
                  l2d_we    = (cnt_ff != '0);
                  l2d_wdata = mem_rdata;
               end
               CP_L2_L1: begin
                  l1d_we    = (cnt_ff != '0);
                  l1d_waddr = {idx1, ww};
                  l1d_wdata = l2d_rdata;
               end
               default: begin
                  l2d_we = 1'b0;
               end
            endcase
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == (WO+1)'(WPB)) begin
               state_in = ret_ff;
            end
         end
         S_WORD: begin
            if (!cmd_ff) begin
               cost_in  = cost_ff + ACC_W'(costs.l1_read);
               state_in = S_WORD_RD;
            end else begin
               l1d_we    = 1'b1;
               l1m_we    = 1'b1;
               l1m_wdata = {1'b1, 1'b1, tag1};
               cost_in   = cost_ff + ACC_W'(costs.l1_write);
               state_in  = S_DONE;
            end
         end
         S_WORD_RD: begin
            rdata_in = l1d_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load) begin
               time_in  = time_ff + TIME_W'(cost_ff);
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // result register, loaded once the previous item has been taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_rdata_in = rsp_rdata_ff;
      rsp_hit1_in  = rsp_hit1_ff;
      rsp_hit2_in  = rsp_hit2_ff;
      rsp_cost_in  = rsp_cost_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_rdata_in = rdata_ff;
         rsp_hit1_in  = hit1_ff;
         rsp_hit2_in  = hit2_ff;
         rsp_cost_in  = (cost_ff > ACC_W'(COST_MAX)) ? COST_MAX : cost_ff[COST_W-1:0];
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff       <= ret_in;
      kind_ff      <= kind_in;
      cnt_ff       <= cnt_in;
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      wdata_ff     <= wdata_in;
      cost_ff      <= cost_in;
      hit1_ff      <= hit1_in;
      hit2_ff      <= hit2_in;
      rdata_ff     <= rdata_in;
      op2_ff       <= op2_in;
      l2_line_ff   <= l2_line_in;
      mem_line_ff  <= mem_line_in;
      rsp_rdata_ff <= rsp_rdata_in;
      rsp_hit1_ff  <= rsp_hit1_in;
      rsp_hit2_ff  <= rsp_hit2_in;
      rsp_cost_ff  <= rsp_cost_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.read_data    = rsp_rdata_ff;
   assign rsp_ch.l1_hit       = rsp_hit1_ff;
   assign rsp_ch.l2_hit       = rsp_hit2_ff;
   assign rsp_ch.access_cost  = rsp_cost_ff;
   assign rsp_ch.elapsed_time = time_ff;

`ifndef SYNTHESIS
   a_copy_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |-> (cnt_ff <= (WO+1)'(WPB)))
      else $error("block copy ran past its last word");

   a_no_accept_in_clear: assert property (@(posedge clock)
      (state_ff == S_CLEAR) |-> !req_ch.ready)
      else $error("item accepted during clearing pass");

   a_hit_flags: assert property (@(posedge clock) disable iff (reset)
      load |=> !(rsp_ch.l1_hit && rsp_ch.l2_hit))
      else $error("l2 hit reported on an l1 hit");

   a_cost_sat: assert property (@(posedge clock) disable iff (reset)
      (load && cost_ff > ACC_W'(COST_MAX)) |=> (rsp_ch.access_cost == COST_MAX))
      else $error("access cost not saturated");

   a_time_step: assert property (@(posedge clock) disable iff (reset)
      load |=> (time_ff == $past(time_ff) + TIME_W'($past(cost_ff))))
      else $error("elapsed time did not advance by the item cost");
`endif

endmodule

// File: hdl/ctc_ram.sv
module ctc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/ctc_csr.sv
module ctc_csr import ctc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_data,
   output cost_cfg_type      costs
);

   cost_cfg_type costs_ff;
   cost_cfg_type costs_in;

   always_comb begin
      costs_in = costs_ff;
      if (csr_write) begin
         case (csr_index)
            CFG_L1_READ:   costs_in.l1_read = csr_data;
            CFG_L1_WRITE:  costs_in.l1_write = csr_data;
            CFG_L2_READ:   costs_in.l2_read = csr_data;
            CFG_L2_WRITE:  costs_in.l2_write = csr_data;
            CFG_MEM_READ:  costs_in.mem_read = csr_data;
            CFG_MEM_WRITE: costs_in.mem_write = csr_data;
            default:       costs_in = costs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         costs_ff.l1_read   <= 8'd1;
         costs_ff.l1_write  <= 8'd1;
         costs_ff.l2_read   <= 8'd10;
         costs_ff.l2_write  <= 8'd10;
         costs_ff.mem_read  <= 8'd100;
         costs_ff.mem_write <= 8'd100;
      end else begin
         costs_ff <= costs_in;
      end
   end

   assign costs = costs_ff;

endmodule

// File: tb/sv/ctc_checker.sv
module ctc_checker import ctc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   ctc_req_if                req,
   ctc_rsp_if                rsp,
   input  logic              csr_write,
   input  logic [CIDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]  csr_data,
   output int                fail_count,
   output int                results_owed
);

   localparam int WORDS_PER_BLOCK = 16;

   typedef struct packed {
      logic [WORD_W-1:0] rdata;
      logic              l1h;
      logic              l2h;
      logic [COST_W-1:0] cost;
      logic [TIME_W-1:0] elapsed;
   } outcome_type;

   bit [31:0] l1_data [4096];
   bit [5:0]  l1_tag [256];
   bit        l1_vld [256];
   bit        l1_drt [256];
   bit [31:0] l2_data [8192];
   bit [4:0]  l2_tag [512];
   bit        l2_vld [512];
   bit        l2_drt [512];
   bit [31:0] mem_words [262144];
   bit [31:0] time_acc;
   cost_cfg_type costs;
   outcome_type owed_q [$];

   // flush an l2 line to memory if dirty
   function automatic int unsigned l2_spill(int unsigned li);
      int unsigned vb;
      int unsigned c;
      c = 0;
      if (l2_vld[li] && l2_drt[li]) begin
         vb = l2_tag[li] * 512 + li;
         for (int w = 0; w < WORDS_PER_BLOCK; w++)
            mem_words[vb * WORDS_PER_BLOCK + w] = l2_data[li * WORDS_PER_BLOCK + w];
         c = 32'(costs.mem_write);
      end
      l2_vld[li] = 0;
      l2_drt[li] = 0;
      return c;
   endfunction

   // block out of l2 into an l1 line, filling l2 from memory on a miss
   function automatic int unsigned l2_fetch(logic [13:0] blk, int unsigned dst, output bit hit);
      int unsigned li;
      int unsigned c;
      li = 32'(blk[8:0]);
      c = 0;
      hit = l2_vld[li] && l2_tag[li] == blk[13:9];
      if (!hit) begin
         c += l2_spill(li);
         for (int w = 0; w < WORDS_PER_BLOCK; w++)
            l2_data[li * WORDS_PER_BLOCK + w] = mem_words[blk * WORDS_PER_BLOCK + w];
         c += costs.mem_read;
         l2_vld[li] = 1;
         l2_tag[li] = blk[13:9];
         l2_drt[li] = 0;
      end
      for (int w = 0; w < WORDS_PER_BLOCK; w++)
         l1_data[dst * WORDS_PER_BLOCK + w] = l2_data[li * WORDS_PER_BLOCK + w];
      return c + costs.l2_read;
   endfunction

   // l1 victim into l2, allocating without a memory read
   function automatic int unsigned l2_store(logic [13:0] blk, int unsigned src);
      int unsigned li;
      int unsigned c;
      li = 32'(blk[8:0]);
      c = 0;
      if (!(l2_vld[li] && l2_tag[li] == blk[13:9])) begin
         c += l2_spill(li);
         l2_vld[li] = 1;
         l2_tag[li] = blk[13:9];
      end
      for (int w = 0; w < WORDS_PER_BLOCK; w++)
         l2_data[li * WORDS_PER_BLOCK + w] = l1_data[src * WORDS_PER_BLOCK + w];
      l2_drt[li] = 1;
      return c + costs.l2_write;
   endfunction

   function automatic outcome_type predict_access(bit is_write, logic [19:0] a,
                                                  logic [31:0] d);
      logic [13:0] blk;
      int unsigned li;
      int unsigned wd;
      int unsigned c;
      bit h1;
      bit h2;
      outcome_type r;
      blk = a[19:6];
      wd = 32'(a[5:2]);
      li = 32'(blk[7:0]);
      c = 0;
      h2 = 0;
      r.rdata = '0;
      h1 = l1_vld[li] && l1_tag[li] == blk[13:8];
      if (!h1) begin
         if (l1_vld[li] && l1_drt[li])
            c += l2_store({l1_tag[li], blk[7:0]}, li);
         c += l2_fetch(blk, li, h2);
         l1_vld[li] = 1;
         l1_tag[li] = blk[13:8];
         l1_drt[li] = 0;
      end
      if (!is_write) begin
         r.rdata = l1_data[li * WORDS_PER_BLOCK + wd];
         c += costs.l1_read;
      end else begin
         l1_data[li * WORDS_PER_BLOCK + wd] = d;
         l1_drt[li] = 1;
         c += costs.l1_write;
      end
      time_acc += c;
      r.l1h = h1;
      r.l2h = h2;
      r.cost = (c > 1023) ? COST_MAX : c[COST_W-1:0];
      r.elapsed = time_acc;
      return r;
   endfunction

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         for (int i = 0; i < 256; i++) begin
            l1_vld[i] = 0;
            l1_drt[i] = 0;
            l1_tag[i] = '0;
         end
         for (int i = 0; i < 512; i++) begin
            l2_vld[i] = 0;
            l2_drt[i] = 0;
            l2_tag[i] = '0;
         end
         time_acc = '0;
         costs = '{l1_read: 8'd1, l1_write: 8'd1, l2_read: 8'd10, l2_write: 8'd10,
                   mem_read: 8'd100, mem_write: 8'd100};
         owed_q.delete();
         fail_count = 0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CFG_L1_READ:   costs.l1_read = csr_data;
               CFG_L1_WRITE:  costs.l1_write = csr_data;
               CFG_L2_READ:   costs.l2_read = csr_data;
               CFG_L2_WRITE:  costs.l2_write = csr_data;
               CFG_MEM_READ:  costs.mem_read = csr_data;
               CFG_MEM_WRITE: costs.mem_write = csr_data;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            if (owed_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result: data %h l1 %b l2 %b cost %0d time %0d",
                           rsp.read_data, rsp.l1_hit, rsp.l2_hit, rsp.access_cost,
                           rsp.elapsed_time);
            end else begin
               e = owed_q.pop_front();
               if (rsp.read_data !== e.rdata || rsp.l1_hit !== e.l1h || rsp.l2_hit !== e.l2h ||
                   rsp.access_cost !== e.cost || rsp.elapsed_time !== e.elapsed) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: exp data %h l1 %b l2 %b cost %0d time %0d / got %h %b %b %0d %0d",
                              e.rdata, e.l1h, e.l2h, e.cost, e.elapsed, rsp.read_data,
                              rsp.l1_hit, rsp.l2_hit, rsp.access_cost, rsp.elapsed_time);
               end
            end
         end
         if (req.valid && req.ready)
            owed_q.push_back(predict_access(req.command, req.address, req.write_data));
      end
      results_owed = owed_q.size();
   end

endmodule

// File: tb/sv/tb.sv
module tb;
   import ctc_pkg::*;

   localparam bit CMD_READ = 1'b0;
   localparam bit CMD_WRITE = 1'b1;
   localparam logic [CIDX_W-1:0] CFG_UNUSED = 3'd6;
   // nothing is accepted during the clearing pass after reset
   localparam int WATCHDOG_LIMIT = 1000000;
   localparam int PHASE_ITEMS = 300;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CIDX_W-1:0] csr_index;
   logic [CFG_W-1:0] csr_data;
   int fail_count;
   int results_owed;

   int burst_left = 0;
   int idle_cycles = 0;
   // receiver stall state
   bit long_hold_req = 0;
   bit hold_started = 0;
   int hold_left = 0;
   int rx_mode = 0;
   int rx_mode_left = 0;

   ctc_req_if req ();
   ctc_rsp_if rsp ();

   two_level_writeback_cache i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req),
      .rsp_ch    (rsp),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   ctc_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .rsp          (rsp),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .fail_count   (fail_count),
      .results_owed (results_owed)
   );

   initial clock = 0;
   always #2 clock = ~clock;

   // one item, sent in bursts with random gaps between them
   task automatic offer(bit cmd, logic [19:0] a, logic [31:0] d);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req.valid <= 0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req.valid <= 1;
      req.command <= cmd;
      req.address <= a;
      req.write_data <= d;
      do @(posedge clock); while (!req.ready);
   endtask

   // drain everything before touching the cost registers
   task automatic settle();
      @(negedge clock);
      req.valid <= 0;
      burst_left = 0;
      while (results_owed != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic csr_put(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
   endtask

   task automatic program_costs(logic [7:0] l1r, logic [7:0] l1w, logic [7:0] l2r,
                                logic [7:0] l2w, logic [7:0] mr, logic [7:0] mw);
      csr_put(CFG_L1_READ, l1r);
      csr_put(CFG_L1_WRITE, l1w);
      csr_put(CFG_L2_READ, l2r);
      csr_put(CFG_L2_WRITE, l2w);
      csr_put(CFG_MEM_READ, mr);
      csr_put(CFG_MEM_WRITE, mw);
      // index past the register list must be ignored
      csr_put(CFG_UNUSED, 8'($urandom));
      @(negedge clock);
      csr_write <= 0;
   endtask

   // mostly a few conflicting blocks so hits, evictions and dirty chains show up
   function automatic logic [19:0] pick_address();
      logic [5:0] tag;
      logic [7:0] idx;
      if ($urandom_range(0, 9) < 3)
         return 20'($urandom);
      tag = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 5));
      idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 3));
      return {tag, idx, 4'($urandom_range(0, 15)), 2'($urandom)};
   endfunction

   // receiver: stall pattern switches among three random modes, plus one long hold-off
   initial begin
      rsp.ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_started) begin
            hold_started = 1;
            hold_left = 500;
         end
         if (rx_mode_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_mode_left = $urandom_range(16, 96);
         end
         rx_mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 0;
         end else begin
            case (rx_mode)
               0: rsp.ready <= 1;
               1: rsp.ready <= 1'($urandom_range(0, 1));
               default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles = 0;
      end else if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      // every input known from time zero
      reset = 1;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      req.valid = 0;
      req.command = CMD_READ;
      req.address = '0;
      req.write_data = '0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // csr writes are taken during the clearing pass
      program_costs(8'd1, 8'd1, 8'd10, 8'd10, 8'd100, 8'd100);

      // directed: cold misses, field extremes, hits, l1 and l2 conflicts
      offer(CMD_READ, 20'h00000, 32'h0);
      offer(CMD_WRITE, 20'h00000, 32'hFFFF_FFFF);
      offer(CMD_READ, 20'h00003, 32'hFFFF_FFFF);
      offer(CMD_WRITE, 20'hFFFFC, 32'hA5A5_5A5A);
      offer(CMD_READ, 20'hFFFFF, 32'h0);
      offer(CMD_WRITE, 20'h0003C, 32'h0000_0001);
      // same l1 line, other l2 line: dirty victim goes to l2
      offer(CMD_READ, 20'h04000, 32'h0);
      offer(CMD_READ, 20'h00000, 32'h0);
      // same l1 and l2 line: l2 victim pushed to memory
      offer(CMD_WRITE, 20'h08000, 32'h1234_5678);
      offer(CMD_READ, 20'h10000, 32'h0);
      offer(CMD_READ, 20'h08000, 32'h0);
      offer(CMD_READ, 20'h00000, 32'h0);
      offer(CMD_READ, 20'h0003C, 32'h0);
      offer(CMD_WRITE, 20'h7FFC0, 32'h8000_0000);
      offer(CMD_READ, 20'hFFFC0, 32'h0);
      offer(CMD_READ, 20'h7FFC0, 32'h0);
      offer(CMD_WRITE, 20'h00040, 32'h0);
      offer(CMD_READ, 20'hFFFFC, 32'h0);
      settle();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: program_costs(8'd1, 8'd1, 8'd10, 8'd10, 8'd100, 8'd100);
            1: program_costs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
            2: program_costs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
            3: program_costs(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255);
            default: program_costs(8'($urandom), 8'($urandom), 8'($urandom),
                                   8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long receiver hold-off while items keep coming
            if (phase == 1 && n == 40)
               long_hold_req = 1;
            offer(bit'($urandom_range(0, 1)), pick_address(), $urandom);
         end
         settle();
      end

      if (fail_count == 0 && results_owed == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
